// ===== hdl/apd_pkg.sv =====
// Shared types and constants for the acknowledge pulse detector.
package apd_pkg;

    localparam int US_BITS    = 20;
    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 8;
    localparam int CFG_BITS   = 20;
    localparam int ADDR_BITS  = 2;

    localparam logic ACT_ARM    = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] STAT_WAIT  = 2'd0;
    localparam logic [1:0] STAT_ACK   = 2'd1;
    localparam logic [1:0] STAT_NOACK = 2'd2;

    localparam logic [ADDR_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [ADDR_BITS-1:0] REG_MIN_PULSE = 2'd1;
    localparam logic [ADDR_BITS-1:0] REG_MAX_PULSE = 2'd2;
    localparam logic [ADDR_BITS-1:0] REG_TIMEOUT   = 2'd3;

    localparam logic [US_BITS-1:0]    MIN_PULSE_RST = 20'd2000;
    localparam logic [US_BITS-1:0]    MAX_PULSE_RST = 20'd20000;
    localparam logic [COUNT_BITS-1:0] TIMEOUT_RST   = 8'd6;

    // Number of further low samples after the first that close a pulse.
    localparam logic [1:0] LOW_TO_CLOSE = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic       cut;
    } t_flags;

endpackage

// ===== hdl/ack_pulse_detector.sv =====
// Top level of the acknowledge pulse detector with its output skid buffer.
//
// Use: configure the threshold, pulse window and reset-count limit through the
// write port while the block is idle. Each input item is either an arm command
// (tuser low), which clears the statistics and starts a wait, or a current
// sample (tuser high) with its reset count and microsecond timestamp.
// Every input item yields exactly one result item giving the wait status, peak
// current, last pulse length, sample and gap counts, and a flag that is set
// only on the item that accepted an acknowledge.
// Results are registered. One item is taken in every cycle while tready is high;
// the state update is a single compare, subtract and count step, so the detector
// state is current for the next item at once.
// When the receiver stalls, one further result is held in a skid register and
// tready falls only once both the output and skid registers are full.
// Reset clears the detector to the not-waiting state, empties both result
// registers and loads the default configuration.
module ack_pulse_detector #(
    parameter int CURRENT_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [apd_pkg::ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [apd_pkg::CFG_BITS-1:0]    i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // current_sample, resets_since_packet, now_us
    input  logic [((CURRENT_BITS+40+7)/8)*8-1:0] i_s_tdata,
    // action
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // ack_status, peak_current, measured_pulse_us, samples_seen, gaps_seen, cut_repeats
    output logic [((CURRENT_BITS+51+7)/8)*8-1:0] o_m_tdata
);
    import apd_pkg::*;

    localparam int OUT_W = ((CURRENT_BITS + 51 + 7) / 8) * 8;
    localparam int RES_LSB  = CURRENT_BITS;
    localparam int NOW_LSB  = CURRENT_BITS + COUNT_BITS;
    localparam int STAT_LSB = 0;
    localparam int CUT_BIT  = CURRENT_BITS + 50;

    t_flags                  w_flags;
    logic [CURRENT_BITS-1:0] w_peak;
    logic [TIME_BITS-1:0]    w_pulse;
    logic [COUNT_BITS-1:0]   w_samples;
    logic [COUNT_BITS-1:0]   w_gaps;
    logic [OUT_W-1:0]        w_result;
    logic                    w_accept;
    logic                    w_taken;

    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out;
    logic                    r_skid_valid;
    logic [OUT_W-1:0]        r_skid;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_taken    = r_out_valid && i_m_tready;

    apd_core #(
        .CURRENT_BITS(CURRENT_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .i_accept  (w_accept),
        .i_action  (i_s_tuser),
        .i_current (i_s_tdata[CURRENT_BITS-1:0]),
        .i_resets  (i_s_tdata[RES_LSB +: COUNT_BITS]),
        .i_now     (i_s_tdata[NOW_LSB +: TIME_BITS]),
        .o_flags   (w_flags),
        .o_peak    (w_peak),
        .o_pulse   (w_pulse),
        .o_samples (w_samples),
        .o_gaps    (w_gaps)
    );

    assign w_result = OUT_W'({w_flags.cut, w_gaps, w_samples, w_pulse, w_peak,
                              w_flags.status});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_taken) begin
                r_out_valid  <= r_skid_valid || w_accept;
                r_skid_valid <= 1'b0;
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_taken) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end
        if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output register is empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_out_valid && !i_m_tready) |=> r_skid_valid)
        else $error("item accepted under a stall was not kept in the skid register");

    a_cut_means_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[CUT_BIT])
            |-> (o_m_tdata[STAT_LSB +: 2] == STAT_ACK))
        else $error("cut flag set without an acknowledge status");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[STAT_LSB +: 2] == STAT_WAIT
                     || o_m_tdata[STAT_LSB +: 2] == STAT_ACK
                     || o_m_tdata[STAT_LSB +: 2] == STAT_NOACK))
        else $error("result status carries an unused code");

    a_arm_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tuser == ACT_ARM) |-> (w_flags.status == STAT_WAIT && !w_flags.cut))
        else $error("arm item did not start a wait");

endmodule

// ===== hdl/apd_core.sv =====
// Detector state, configuration registers and the per-item update.
module apd_core #(
    parameter int CURRENT_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [apd_pkg::ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [apd_pkg::CFG_BITS-1:0]    i_cfg_data,
    input  logic                            i_accept,
    input  logic                            i_action,
    input  logic [CURRENT_BITS-1:0]         i_current,
    input  logic [apd_pkg::COUNT_BITS-1:0]  i_resets,
    input  logic [apd_pkg::TIME_BITS-1:0]   i_now,
    output apd_pkg::t_flags                 o_flags,
    output logic [CURRENT_BITS-1:0]         o_peak,
    output logic [apd_pkg::TIME_BITS-1:0]   o_pulse,
    output logic [apd_pkg::COUNT_BITS-1:0]  o_samples,
    output logic [apd_pkg::COUNT_BITS-1:0]  o_gaps
);
    import apd_pkg::*;

    logic [CURRENT_BITS-1:0] r_threshold;
    logic [US_BITS-1:0]      r_min_pulse;
    logic [US_BITS-1:0]      r_max_pulse;
    logic [COUNT_BITS-1:0]   r_timeout;

    logic                    r_waiting, n_waiting;
    logic                    r_ack_found, n_ack_found;
    logic                    r_in_pulse, n_in_pulse;
    logic [TIME_BITS-1:0]    r_start, n_start;
    logic [TIME_BITS-1:0]    r_length, n_length;
    logic [1:0]              r_low, n_low;
    logic [CURRENT_BITS-1:0] r_max_seen, n_max_seen;
    logic [COUNT_BITS-1:0]   r_samples, n_samples;
    logic [COUNT_BITS-1:0]   r_gaps, n_gaps;
    logic                    w_cut;
    logic                    w_in_window;

    assign w_in_window = (r_length >= TIME_BITS'(r_min_pulse))
                      && (r_length <= TIME_BITS'(r_max_pulse));

    always_comb begin
        n_waiting   = r_waiting;
        n_ack_found = r_ack_found;
        n_in_pulse  = r_in_pulse;
        n_start     = r_start;
        n_length    = r_length;
        n_low       = r_low;
        n_max_seen  = r_max_seen;
        n_samples   = r_samples;
        n_gaps      = r_gaps;
        w_cut       = 1'b0;
        if (i_action == ACT_ARM) begin
            n_waiting   = 1'b1;
            n_ack_found = 1'b0;
            n_in_pulse  = 1'b0;
            n_start     = '0;
            n_length    = '0;
            n_max_seen  = '0;
            n_samples   = '0;
            n_gaps      = '0;
        end else if (r_waiting) begin
            if (i_resets > r_timeout) begin
                n_waiting = 1'b0;
            end else begin
                n_samples = r_samples + 1'b1;
                if (i_current > r_max_seen) begin
                    n_max_seen = i_current;
                end
                if (i_current > r_threshold) begin
                    if (r_low != 2'd0) begin
                        n_gaps = r_gaps + 1'b1;
                        n_low  = 2'd0;
                    end
                    if (!r_in_pulse) begin
                        n_in_pulse = 1'b1;
                        n_start    = i_now;
                    end
                end else if (r_in_pulse) begin
                    if (r_low == 2'd0) begin
                        n_length = i_now - r_start;
                    end
                    if (r_low < LOW_TO_CLOSE) begin
                        n_low = r_low + 2'd1;
                    end else begin
                        // The third low sample closes the pulse and judges its length.
                        n_low = 2'd0;
                        if (w_in_window) begin
                            n_ack_found = 1'b1;
                            n_waiting   = 1'b0;
                            w_cut       = 1'b1;
                        end else begin
                            n_in_pulse = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_min_pulse <= MIN_PULSE_RST;
            r_max_pulse <= MAX_PULSE_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_THRESHOLD: r_threshold <= i_cfg_data[CURRENT_BITS-1:0];
                REG_MIN_PULSE: r_min_pulse <= i_cfg_data[US_BITS-1:0];
                REG_MAX_PULSE: r_max_pulse <= i_cfg_data[US_BITS-1:0];
                REG_TIMEOUT:   r_timeout   <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting   <= 1'b0;
            r_ack_found <= 1'b0;
            r_in_pulse  <= 1'b0;
            r_start     <= '0;
            r_length    <= '0;
            r_low       <= 2'd0;
            r_max_seen  <= '0;
            r_samples   <= '0;
            r_gaps      <= '0;
        end else if (i_accept) begin
            r_waiting   <= n_waiting;
            r_ack_found <= n_ack_found;
            r_in_pulse  <= n_in_pulse;
            r_start     <= n_start;
            r_length    <= n_length;
            r_low       <= n_low;
            r_max_seen  <= n_max_seen;
            r_samples   <= n_samples;
            r_gaps      <= n_gaps;
        end
    end

    always_comb begin
        o_flags.cut = w_cut;
        priority if (n_waiting) begin
            o_flags.status = STAT_WAIT;
        end else if (n_ack_found) begin
            o_flags.status = STAT_ACK;
        end else begin
            o_flags.status = STAT_NOACK;
        end
    end

    assign o_peak      = n_max_seen;
    assign o_pulse     = n_length;
    assign o_samples   = n_samples;
    assign o_gaps      = n_gaps;

endmodule
